[hw/rtl/assert_macros.svh]
// Assertion macros shared by the execute core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SIE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SIE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sie_pkg.sv]
// Shared types and constants of the SIMP instruction execute core.
package sie_pkg;

    localparam int REG_COUNT  = 16;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int DATA_WORDS = 4096;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);
    localparam int PC_LIMIT   = 1024;
    localparam int PC_W       = $clog2(PC_LIMIT);
    localparam int IMM_W      = 20;
    localparam int XLEN       = 32;

    localparam logic [REG_AW-1:0] IMM_REG  = REG_AW'(1);
    localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(15);
    localparam int                RETI_IO  = 7;

    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,
        OP_SUB  = 8'd1,
        OP_AND  = 8'd2,
        OP_OR   = 8'd3,
        OP_XOR  = 8'd4,
        OP_MUL  = 8'd5,
        OP_SLL  = 8'd6,
        OP_SRA  = 8'd7,
        OP_SRL  = 8'd8,
        OP_BEQ  = 8'd9,
        OP_BNE  = 8'd10,
        OP_BLT  = 8'd11,
        OP_BGT  = 8'd12,
        OP_BLE  = 8'd13,
        OP_BGE  = 8'd14,
        OP_JAL  = 8'd15,
        OP_LW   = 8'd16,
        OP_SW   = 8'd17,
        OP_RETI = 8'd18,
        OP_IN   = 8'd19,
        OP_OUT  = 8'd20,
        OP_HALT = 8'd21
    } op_t;

    typedef enum logic [1:0] {
        IO_NONE  = 2'd0,
        IO_READ  = 2'd1,
        IO_WRITE = 2'd2
    } io_kind_t;

    // Input beat, last declared field (op) in the lowest bits.
    typedef struct packed {
        logic [IMM_W-1:0]  immediate;
        logic [REG_AW-1:0] src_reg_b;
        logic [REG_AW-1:0] src_reg_a;
        logic [REG_AW-1:0] dest_reg;
        logic [7:0]        op;
    } in_item_t;

    localparam int IN_W = $bits(in_item_t);

    typedef struct packed {
        logic [2:0]        pad;
        logic              io_bad_index;
        logic [XLEN-1:0]   io_value;
        logic [4:0]        io_index;
        logic [XLEN-1:0]   written_value;
        logic [REG_AW-1:0] written_reg;
        logic              halted;
        logic [PC_W-1:0]   next_pc;
    } out_data_t;

    localparam int OUT_W = $bits(out_data_t);

    typedef struct packed {
        io_kind_t io_kind;
        logic     reg_written;
    } out_user_t;

    localparam int USER_W = $bits(out_user_t);

endpackage

[hw/rtl/sie_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/simp_instruction_execute_core.sv]
// Top level of the SIMP instruction execute core.
// Result: the result beat is registered as the instruction leaves execute; lw waits there first.
// Throughput: one instruction per cycle while the output is not stalled; lw holds the execute
// stage for the registered read of the data memory.
// Reset: registers, IO registers, PC and halt flag clear at once; the data memory is then
// cleared one word a cycle through all 4096 words, during which s_tready stays low.
`include "assert_macros.svh"

module simp_instruction_execute_core #(
    parameter int IO_COUNT = 22
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op[7:0], dest_reg[11:8], src_reg_a[15:12], src_reg_b[19:16], immediate[39:20]
    input  logic [sie_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // next_pc[9:0], halted[10], written_reg[14:11], written_value[46:15],
    // io_index[51:47], io_value[83:52], io_bad_index[84], zero[87:85]
    output logic [sie_pkg::OUT_W-1:0]    m_tdata,
    // reg_written[0], io_kind[2:1]
    output logic [sie_pkg::USER_W-1:0]   m_tuser
);

    import sie_pkg::*;

    localparam int IO_AW = $clog2(IO_COUNT);

    in_item_t            s_item;
    logic                s_accept;

    // Execute stage.
    logic                ex_valid_reg, ex_valid_next;
    in_item_t            ex_item_reg;
    logic                va_reg, vb_reg, vd_reg;
    logic                fwd_valid_reg;
    logic [REG_AW-1:0]   fwd_idx_reg;
    logic [XLEN-1:0]     fwd_val_reg;
    logic                lw_pend_reg, lw_pend_next;
    logic                ex_lw, ex_can_finish, ex_move;

    // Architectural state.
    logic [PC_W-1:0]     pc_reg;
    logic                halt_flag_reg;
    logic [REG_COUNT-1:0] rvalid_reg;
    logic [XLEN-1:0]     io_reg [IO_COUNT];

    // Data memory clearing after reset.
    logic                clr_active_reg;
    logic [DMEM_AW-1:0]  clr_addr_reg;

    // Output register.
    logic                m_tvalid_reg;
    out_data_t           out_data_reg;
    out_user_t           out_user_reg;

    // Register file and data memory ports.
    logic [XLEN-1:0]     ra_q, rb_q, rd_q;
    logic [XLEN-1:0]     dm_q;
    logic                dm_we;
    logic [DMEM_AW-1:0]  dm_waddr;
    logic [XLEN-1:0]     dm_wdata;

    // Execute results.
    logic [XLEN-1:0]     op_a, op_b, op_d, imm32, sum;
    logic                is_imm, taken, io_ok;
    logic [PC_W-1:0]     seq_pc, npc;
    logic                wr_en, halt_set, io_we, dm_st;
    logic [REG_AW-1:0]   wr_idx;
    logic [XLEN-1:0]     wr_val;
    logic [IO_AW-1:0]    io_addr;
    out_data_t           res_data;
    out_user_t           res_user;

    assign s_item   = in_item_t'(s_tdata);
    assign s_tready = !clr_active_reg && (!ex_valid_reg || ex_move);
    assign s_accept = s_tvalid && s_tready;

    assign ex_lw         = (ex_item_reg.op == OP_LW) && !halt_flag_reg;
    assign ex_can_finish = !ex_lw || lw_pend_reg;
    assign ex_move       = ex_valid_reg && ex_can_finish && (!m_tvalid_reg || m_tready);

    // Three copies of the register file give the rs, rt and rd read ports.
    sie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .aclk  (aclk),
        .we    (ex_move && wr_en),
        .waddr (wr_idx),
        .wdata (wr_val),
        .re    (s_accept),
        .raddr (s_item.src_reg_a),
        .rdata (ra_q)
    );

    sie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .aclk  (aclk),
        .we    (ex_move && wr_en),
        .waddr (wr_idx),
        .wdata (wr_val),
        .re    (s_accept),
        .raddr (s_item.src_reg_b),
        .rdata (rb_q)
    );

    sie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_d (
        .aclk  (aclk),
        .we    (ex_move && wr_en),
        .waddr (wr_idx),
        .wdata (wr_val),
        .re    (s_accept),
        .raddr (s_item.dest_reg),
        .rdata (rd_q)
    );

    sie_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
        .aclk  (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (ex_valid_reg && ex_lw && !lw_pend_reg),
        .raddr (sum[DMEM_AW-1:0]),
        .rdata (dm_q)
    );

    // Register 1 is only ever read by an immediate instruction, which sees the
    // immediate itself, so it needs no storage beyond the file.
    function automatic logic [XLEN-1:0] pick_operand(
        input logic [REG_AW-1:0] idx,
        input logic [XLEN-1:0]   ram_q,
        input logic              ram_valid,
        input logic              imm_hit,
        input logic [XLEN-1:0]   imm_val,
        input logic              fwd_valid,
        input logic [REG_AW-1:0] fwd_idx,
        input logic [XLEN-1:0]   fwd_val
    );
        logic [XLEN-1:0] val;
        if (imm_hit && idx == IMM_REG) begin
            val = imm_val;
        end else if (fwd_valid && idx == fwd_idx) begin
            val = fwd_val;
        end else if (ram_valid) begin
            val = ram_q;
        end else begin
            val = '0;
        end
        return val;
    endfunction

    always_comb begin
        is_imm = (ex_item_reg.dest_reg == IMM_REG) || (ex_item_reg.src_reg_a == IMM_REG)
              || (ex_item_reg.src_reg_b == IMM_REG);
        imm32  = {{(XLEN - IMM_W){ex_item_reg.immediate[IMM_W-1]}}, ex_item_reg.immediate};
        op_a   = pick_operand(ex_item_reg.src_reg_a, ra_q, va_reg, is_imm, imm32,
                              fwd_valid_reg, fwd_idx_reg, fwd_val_reg);
        op_b   = pick_operand(ex_item_reg.src_reg_b, rb_q, vb_reg, is_imm, imm32,
                              fwd_valid_reg, fwd_idx_reg, fwd_val_reg);
        op_d   = pick_operand(ex_item_reg.dest_reg, rd_q, vd_reg, is_imm, imm32,
                              fwd_valid_reg, fwd_idx_reg, fwd_val_reg);
        sum     = op_a + op_b;
        seq_pc  = pc_reg + (is_imm ? PC_W'(2) : PC_W'(1));
        io_ok   = sum < XLEN'(IO_COUNT);
        io_addr = sum[IO_AW-1:0];

        npc      = seq_pc;
        taken    = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = ex_item_reg.dest_reg;
        wr_val   = '0;
        halt_set = 1'b0;
        io_we    = 1'b0;
        dm_st    = 1'b0;
        res_data = '0;
        res_user = '0;

        if (halt_flag_reg) begin
            npc = pc_reg;
        end else begin
            unique case (ex_item_reg.op)
                OP_ADD: begin wr_en = 1'b1; wr_val = op_a + op_b; end
                OP_SUB: begin wr_en = 1'b1; wr_val = op_a - op_b; end
                OP_AND: begin wr_en = 1'b1; wr_val = op_a & op_b; end
                OP_OR:  begin wr_en = 1'b1; wr_val = op_a | op_b; end
                OP_XOR: begin wr_en = 1'b1; wr_val = op_a ^ op_b; end
                OP_MUL: begin wr_en = 1'b1; wr_val = op_a * op_b; end
                OP_SLL: begin wr_en = 1'b1; wr_val = op_a << op_b[4:0]; end
                OP_SRA: begin wr_en = 1'b1; wr_val = $signed(op_a) >>> op_b[4:0]; end
                OP_SRL: begin wr_en = 1'b1; wr_val = op_a >> op_b[4:0]; end
                OP_BEQ: taken = (op_a == op_b);
                OP_BNE: taken = (op_a != op_b);
                OP_BLT: taken = ($signed(op_a) < $signed(op_b));
                OP_BGT: taken = ($signed(op_b) < $signed(op_a));
                OP_BLE: taken = !($signed(op_b) < $signed(op_a));
                OP_BGE: taken = !($signed(op_a) < $signed(op_b));
                OP_JAL: begin
                    npc    = op_d[PC_W-1:0];
                    wr_en  = 1'b1;
                    wr_idx = LINK_REG;
                    wr_val = XLEN'(seq_pc);
                end
                OP_LW:   begin wr_en = 1'b1; wr_val = dm_q; end
                OP_SW:   dm_st = 1'b1;
                OP_RETI: npc = io_reg[RETI_IO][PC_W-1:0];
                OP_IN: begin
                    res_user.io_kind      = IO_READ;
                    res_data.io_index     = sum[4:0];
                    res_data.io_bad_index = !io_ok;
                    res_data.io_value     = io_ok ? io_reg[io_addr] : '0;
                    wr_en                 = 1'b1;
                    wr_val                = io_ok ? io_reg[io_addr] : '0;
                end
                OP_OUT: begin
                    res_user.io_kind      = IO_WRITE;
                    res_data.io_index     = sum[4:0];
                    res_data.io_bad_index = !io_ok;
                    res_data.io_value     = op_d;
                    io_we                 = io_ok;
                end
                OP_HALT: begin
                    halt_set = 1'b1;
                    npc      = pc_reg;
                end
                default: ;
            endcase
            if (taken) begin
                npc = op_d[PC_W-1:0];
            end
        end

        res_data.next_pc       = npc;
        res_data.halted        = halt_flag_reg || halt_set;
        res_user.reg_written   = wr_en;
        res_data.written_reg   = wr_en ? wr_idx : '0;
        res_data.written_value = wr_en ? wr_val : '0;
    end

    // The clearing sweep owns the write port; no instruction runs meanwhile.
    always_comb begin
        if (clr_active_reg) begin
            dm_we    = 1'b1;
            dm_waddr = clr_addr_reg;
            dm_wdata = '0;
        end else begin
            dm_we    = ex_move && dm_st;
            dm_waddr = sum[DMEM_AW-1:0];
            dm_wdata = op_d;
        end
    end

    always_comb begin
        if (s_accept) begin
            ex_valid_next = 1'b1;
        end else if (ex_move) begin
            ex_valid_next = 1'b0;
        end else begin
            ex_valid_next = ex_valid_reg;
        end
        if (ex_move) begin
            lw_pend_next = 1'b0;
        end else if (ex_valid_reg && ex_lw) begin
            lw_pend_next = 1'b1;
        end else begin
            lw_pend_next = lw_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg   <= 1'b0;
            lw_pend_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            pc_reg         <= '0;
            halt_flag_reg  <= 1'b0;
            rvalid_reg     <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < IO_COUNT; i++) begin
                io_reg[i] <= '0;
            end
        end else begin
            ex_valid_reg <= ex_valid_next;
            lw_pend_reg  <= lw_pend_next;

            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + DMEM_AW'(1);
                if (clr_addr_reg == DMEM_AW'(DATA_WORDS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end

            // The register files read before this edge's write; the bypass
            // covers a write landing on the same edge as the read.
            if (s_accept) begin
                fwd_valid_reg <= ex_move && wr_en;
            end

            if (ex_move) begin
                pc_reg <= npc;
                if (halt_set) begin
                    halt_flag_reg <= 1'b1;
                end
                if (wr_en) begin
                    rvalid_reg[wr_idx] <= 1'b1;
                end
                if (io_we) begin
                    io_reg[io_addr] <= op_d;
                end
            end

            if (ex_move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_item_reg <= s_item;
            va_reg      <= rvalid_reg[s_item.src_reg_a];
            vb_reg      <= rvalid_reg[s_item.src_reg_b];
            vd_reg      <= rvalid_reg[s_item.dest_reg];
            fwd_idx_reg <= wr_idx;
            fwd_val_reg <= wr_val;
        end
        if (ex_move) begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `SIE_ASSERT_NXT(a_halt_sticky, aclk, aresetn, halt_flag_reg, halt_flag_reg,
                    "halt flag dropped without reset")
    `SIE_ASSERT_NXT(a_pc_frozen, aclk, aresetn, halt_flag_reg, $stable(pc_reg),
                    "PC moved after halt")
    `SIE_ASSERT_IMP(a_lw_waits, aclk, aresetn, ex_valid_reg && ex_lw && !lw_pend_reg,
                    !ex_move, "lw left execute before its data memory read returned")
    `SIE_ASSERT_IMP(a_clear_quiet, aclk, aresetn, clr_active_reg,
                    !ex_valid_reg && !s_tready, "instruction active during memory clear")
    `SIE_ASSERT_IMP(a_halted_quiet, aclk, aresetn, m_tvalid_reg && out_data_reg.halted,
                    !out_user_reg.reg_written && (out_user_reg.io_kind == IO_NONE),
                    "halted beat reports a register or IO access")

endmodule

[tb/simp_instruction_execute_core_tb.sv]
// Self-checking testbench of the SIMP instruction execute core.
`timescale 1ns / 100ps

module simp_instruction_execute_core_tb;
    import sie_pkg::*;

    localparam int IO_REGS = 22;

    // Shadow copy of the core: predicts one result beat per instruction beat.
    class core_scoreboard;
        logic [31:0] regs [REG_COUNT];
        logic [31:0] dmem [DATA_WORDS];
        logic [31:0] ioregs [IO_REGS];
        logic [31:0] pc;
        bit          halted;
        out_data_t   exp_data_q [$];
        out_user_t   exp_user_q [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            foreach (ioregs[i]) ioregs[i] = '0;
            pc = '0;
            halted = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return exp_data_q.size();
        endfunction

        function logic [31:0] jump_target(logic [31:0] v);
            return (v & 32'h3FF) % PC_LIMIT;
        endfunction

        function void note_instr(in_item_t it);
            logic [31:0] imm32, a, b, d, sum, seq, npc, wval;
            bit          isimm, taken, wr;
            out_data_t   ed;
            out_user_t   eu;
            ed = '0;
            eu = '0;
            taken = 1'b0;
            wr = 1'b0;
            wval = '0;
            if (halted) begin
                ed.next_pc = pc[PC_W-1:0];
                ed.halted = 1'b1;
                exp_data_q.push_back(ed);
                exp_user_q.push_back(eu);
                return;
            end
            imm32 = {{(XLEN-IMM_W){it.immediate[IMM_W-1]}}, it.immediate};
            isimm = (it.dest_reg == IMM_REG) || (it.src_reg_a == IMM_REG) ||
                    (it.src_reg_b == IMM_REG);
            // Register 1 takes the immediate before the operands are read.
            if (isimm) regs[IMM_REG] = imm32;
            seq = (pc + (isimm ? 32'd2 : 32'd1)) % PC_LIMIT;
            npc = seq;
            a = regs[it.src_reg_a];
            b = regs[it.src_reg_b];
            d = regs[it.dest_reg];
            sum = a + b;
            case (it.op)
                OP_ADD: begin wr = 1'b1; wval = a + b; end
                OP_SUB: begin wr = 1'b1; wval = a - b; end
                OP_AND: begin wr = 1'b1; wval = a & b; end
                OP_OR:  begin wr = 1'b1; wval = a | b; end
                OP_XOR: begin wr = 1'b1; wval = a ^ b; end
                OP_MUL: begin wr = 1'b1; wval = a * b; end
                OP_SLL: begin wr = 1'b1; wval = a << b[4:0]; end
                OP_SRA: begin wr = 1'b1; wval = $signed(a) >>> b[4:0]; end
                OP_SRL: begin wr = 1'b1; wval = a >> b[4:0]; end
                OP_BEQ: taken = (a == b);
                OP_BNE: taken = (a != b);
                OP_BLT: taken = ($signed(a) < $signed(b));
                OP_BGT: taken = ($signed(b) < $signed(a));
                OP_BLE: taken = !($signed(b) < $signed(a));
                OP_BGE: taken = !($signed(a) < $signed(b));
                OP_JAL: begin
                    npc = jump_target(d);
                    regs[LINK_REG] = seq;
                    eu.reg_written = 1'b1;
                    ed.written_reg = LINK_REG;
                    ed.written_value = seq;
                end
                OP_LW: begin wr = 1'b1; wval = dmem[sum % DATA_WORDS]; end
                OP_SW: dmem[sum % DATA_WORDS] = d;
                OP_RETI: npc = jump_target(ioregs[RETI_IO]);
                OP_IN: begin
                    eu.io_kind = IO_READ;
                    ed.io_index = sum[4:0];
                    if (sum < IO_REGS) ed.io_value = ioregs[sum];
                    else ed.io_bad_index = 1'b1;
                    wr = 1'b1;
                    wval = ed.io_value;
                end
                OP_OUT: begin
                    eu.io_kind = IO_WRITE;
                    ed.io_index = sum[4:0];
                    ed.io_value = d;
                    if (sum < IO_REGS) ioregs[sum] = d;
                    else ed.io_bad_index = 1'b1;
                end
                OP_HALT: begin
                    halted = 1'b1;
                    npc = pc;
                end
                default: ;
            endcase
            if (taken) npc = jump_target(d);
            if (wr) begin
                regs[it.dest_reg] = wval;
                eu.reg_written = 1'b1;
                ed.written_reg = it.dest_reg;
                ed.written_value = wval;
            end
            pc = npc;
            ed.next_pc = npc[PC_W-1:0];
            ed.halted = halted;
            exp_data_q.push_back(ed);
            exp_user_q.push_back(eu);
        endfunction

        function void compare(string field, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, e, a);
                errors++;
            end
        endfunction

        function void check_result(out_data_t d, out_user_t u);
            out_data_t ed;
            out_user_t eu;
            if (exp_data_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, d);
                errors++;
                return;
            end
            ed = exp_data_q.pop_front();
            eu = exp_user_q.pop_front();
            compare("next_pc", ed.next_pc, d.next_pc);
            compare("halted", ed.halted, d.halted);
            compare("reg_written", eu.reg_written, u.reg_written);
            compare("written_reg", ed.written_reg, d.written_reg);
            compare("written_value", ed.written_value, d.written_value);
            compare("io_kind", eu.io_kind, u.io_kind);
            compare("io_index", ed.io_index, d.io_index);
            compare("io_value", ed.io_value, d.io_value);
            compare("io_bad_index", ed.io_bad_index, d.io_bad_index);
            compare("pad", ed.pad, d.pad);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic [USER_W-1:0]     m_tuser;

    int unsigned send_idle_pct = 13;
    int unsigned recv_idle_pct = 55;

    core_scoreboard sb = new();

    simp_instruction_execute_core #(
        .IO_COUNT(IO_REGS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(out_data_t'(m_tdata), out_user_t'(m_tuser));
    end

    function automatic in_item_t mk(logic [7:0] op, logic [3:0] rd, logic [3:0] rs,
                                    logic [3:0] rt, int imm);
        in_item_t it;
        it.op = op;
        it.dest_reg = rd;
        it.src_reg_a = rs;
        it.src_reg_b = rt;
        it.immediate = imm[IMM_W-1:0];
        return it;
    endfunction

    // Aims R[rs]+R[rt] at the target; the fallback rs = rt = R1 drops bit 0 of it.
    function automatic in_item_t aim_sum(in_item_t it, logic [31:0] target);
        logic [31:0] diff;
        logic [3:0]  rt;
        rt = 4'($urandom_range(0, 15));
        diff = target - sb.regs[rt];
        it.src_reg_a = IMM_REG;
        if (rt != IMM_REG && $signed(diff) >= -524288 && $signed(diff) <= 524287) begin
            it.src_reg_b = rt;
            it.immediate = diff[IMM_W-1:0];
        end else begin
            it.src_reg_b = IMM_REG;
            it.immediate = target[IMM_W:1];
        end
        return it;
    endfunction

    function automatic in_item_t gen_instr();
        in_item_t it;
        it.dest_reg = 4'($urandom_range(0, 15));
        it.src_reg_a = 4'($urandom_range(0, 15));
        it.src_reg_b = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0)
            it.immediate = IMM_W'(int'($urandom_range(0, 63)) - 32);
        else
            it.immediate = IMM_W'($urandom);
        if ($urandom_range(0, 99) < 20) begin
            // Noise: any opcode, halt kept back for the end of the run.
            it.op = 8'($urandom_range(0, 255));
            if (it.op == OP_HALT) it.op = 8'hFF;
            return it;
        end
        it.op = 8'($urandom_range(0, int'(OP_OUT)));
        case (it.op)
            OP_LW, OP_SW: begin
                if ($urandom_range(0, 99) < 70)
                    it = aim_sum(it, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                                                 : $urandom_range(0, 4095));
            end
            OP_IN, OP_OUT: begin
                if ($urandom_range(0, 99) < 30)
                    it = aim_sum(it, RETI_IO);
                else if ($urandom_range(0, 99) < 90)
                    it = aim_sum(it, $urandom_range(0, 25));
            end
            OP_BEQ, OP_BNE, OP_BLE, OP_BGE: begin
                if ($urandom_range(0, 2) == 0) it.src_reg_b = it.src_reg_a;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_instr(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = it;
        do @(posedge aclk); while (!s_tready);
        sb.note_instr(it);
    endtask

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++) send_instr(gen_instr());
    endtask

    // Holds the sender until every predicted result beat has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic directed_program();
        send_instr(mk(OP_ADD, 2, 1, 0, 524287));
        send_instr(mk(OP_SUB, 3, 0, 1, -524288));
        send_instr(mk(OP_MUL, 4, 2, 2, 0));
        send_instr(mk(OP_AND, 5, 4, 3, 0));
        send_instr(mk(OP_OR, 6, 4, 3, 0));
        send_instr(mk(OP_XOR, 7, 4, 2, 0));
        send_instr(mk(OP_SLL, 8, 1, 1, -1));
        // Shift amounts above 31 wrap around.
        send_instr(mk(OP_SRA, 9, 8, 1, 35));
        send_instr(mk(OP_SRL, 10, 8, 1, 3));
        send_instr(mk(OP_ADD, 1, 0, 0, 9));
        // Taken branch to the top PC, then the sequential PC wraps.
        send_instr(mk(OP_BEQ, 1, 2, 2, -1));
        send_instr(mk(OP_BNE, 1, 2, 2, 5));
        send_instr(mk(OP_BLT, 1, 8, 0, 100));
        send_instr(mk(OP_BGT, 1, 8, 0, 100));
        send_instr(mk(OP_BLE, 1, 0, 0, 200));
        send_instr(mk(OP_BGE, 1, 8, 0, 300));
        send_instr(mk(OP_JAL, 1, 0, 0, 1020));
        // Address 0xFFFFFFFF folds onto the last data word.
        send_instr(mk(OP_SW, 4, 1, 0, -1));
        send_instr(mk(OP_LW, 11, 1, 0, -1));
        send_instr(mk(OP_OUT, 4, 1, 0, RETI_IO));
        send_instr(mk(OP_IN, 12, 1, 0, RETI_IO));
        send_instr(mk(OP_RETI, 0, 0, 0, 0));
        send_instr(mk(OP_OUT, 4, 1, 0, IO_REGS));
        send_instr(mk(OP_IN, 13, 1, 0, -1));
        send_instr(mk(OP_IN, 13, 1, 0, IO_REGS - 1));
        send_instr(mk(8'hFF, 2, 1, 0, 1));
        send_instr(mk(OP_ADD, 0, 1, 1, 3));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 55;
        directed_program();
        random_burst(380);
        drain_results();

        send_idle_pct = 55;
        recv_idle_pct = 13;
        random_burst(380);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(385);
        // Once halted, the core only reports the held PC.
        send_instr(mk(OP_HALT, 3, 1, 2, 77));
        random_burst(6);
        drain_results();

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
